// ===== rtl/vdpvlt_pkg.sv =====
// ----------------------------------------------------------------------------
// vdpvlt_pkg: shared constants, types and functions
// Function codes, timing constants, result layout and the address fold
// that maps the 14-bit access address onto the video memory.
// ----------------------------------------------------------------------------
`default_nettype none

package vdpvlt_pkg;

  localparam int MEM_BYTES       = 16384;
  localparam int VISIBLE_LINES   = 192;
  localparam int LINES_PER_FRAME = 262;

  localparam int ADDR_W = 14;
  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam int LINE_W = 9;

  // Number of conditional subtractions that fold any 14-bit address below MEM_BYTES.
  localparam int WRAP_STEPS = ((2 ** ADDR_W) - 1) / MEM_BYTES;

  localparam logic [ADDR_W:0] MEM_BYTES_W = (ADDR_W + 1)'(MEM_BYTES);
  localparam logic [MEM_AW-1:0] MEM_LAST  = MEM_AW'(MEM_BYTES - 1);
  localparam logic [LINE_W-1:0] VIS_LINE  = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W-1:0] LPF_LINE  = LINE_W'(LINES_PER_FRAME);

  typedef logic [2:0] func_t;

  localparam func_t FN_DATA_READ  = 3'd0;
  localparam func_t FN_DATA_WRITE = 3'd1;
  localparam func_t FN_STATUS     = 3'd2;
  localparam func_t FN_CONTROL    = 3'd3;
  localparam func_t FN_LINE_END   = 3'd4;

  // Mode register indexes.
  localparam logic [2:0] REG_MODE0 = 3'd0;
  localparam logic [2:0] REG_MODE1 = 3'd1;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_GFX1  = 2'd0;
  localparam mode_t MODE_GFX2  = 2'd1;
  localparam mode_t MODE_MULTI = 2'd2;
  localparam mode_t MODE_TEXT  = 2'd3;

  // Packed highest field first, so rdata lands in the lowest bits.
  typedef struct packed {
    logic              display_on;
    mode_t             screen_mode;
    logic [LINE_W-1:0] line_number;
    logic              draw_line;
    logic              frame_start;
    logic              irq_pulse;
    logic [7:0]        rdata;
  } res_t;

  function automatic logic [MEM_AW-1:0] mem_index(logic [ADDR_W-1:0] a);
    logic [ADDR_W:0] v;
    v = {1'b0, a};
    for (int i = 0; i < WRAP_STEPS; i++) begin
      if (v >= MEM_BYTES_W) begin
        v = v - MEM_BYTES_W;
      end
    end
    return v[MEM_AW-1:0];
  endfunction

  function automatic mode_t screen_mode(logic [7:0] reg0, logic [7:0] reg1);
    mode_t m;
    if (reg1[4]) begin
      m = MODE_TEXT;
    end else if (reg1[3]) begin
      m = MODE_MULTI;
    end else if (reg0[1]) begin
      m = MODE_GFX2;
    end else begin
      m = MODE_GFX1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vdpvlt_ram.sv =====
// ----------------------------------------------------------------------------
// vdpvlt_ram: generic simple dual-port RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vdpvlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/vdp_vram_port_and_line_timing.sv =====
// ----------------------------------------------------------------------------
// vdp_vram_port_and_line_timing: CPU port and scanline timing of a VDP
// Video memory with auto-incrementing access address, read-ahead byte,
// two-write control latch, mode registers, frame flag and line counter.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Contents
//  --------+-----------+--------------------+---------------------------------
//  in_     | input     | tvalid / tready    | tuser = func, tdata = wdata
//  out_    | output    | tvalid / tready    | one result word per input word
//
//  A new word is taken each cycle while the output register is empty or being
//  drained. A memory read is issued at acceptance and its byte is forwarded to
//  the word in the next cycle.
//  After reset the block clears the video memory, one byte per cycle, with
//  in_tready low. A stalled output holds its word and stalls the input.
`default_nettype none

module vdp_vram_port_and_line_timing
  import vdpvlt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] wdata
  input  wire logic [2:0]  in_tuser,   // [2:0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] rdata, [8] irq_pulse, [9] frame_start, [10] draw_line,
  // [19:11] line_number, [21:20] screen_mode, [22] display_on, [23] zero
  output logic [23:0]      out_tdata
);

  logic              clearing_r;
  logic [MEM_AW-1:0] clr_addr_r;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              pend_r, pend_nxt;
  logic [7:0]        first_r, first_nxt;
  logic [7:0]        ahead_r, ahead_nxt;
  logic              fill_r, fill_nxt;
  logic              flag_r, flag_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              irq_r, irq_nxt;
  logic [7:0]        mode_r   [8];
  logic [7:0]        mode_nxt [8];
  logic              out_valid_r;
  res_t              res_r, res_nxt;

  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [MEM_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic              acc;
  logic [7:0]        ahead_eff;
  logic [ADDR_W-1:0] ctrl_addr;
  func_t             func;
  logic [7:0]        wd;

  assign func      = in_tuser;
  assign wd        = in_tdata;
  assign in_tready = !clearing_r && (!out_valid_r || out_tready);
  assign acc       = in_tvalid && in_tready;
  // A prefetch issued last cycle has not reached the read-ahead register yet.
  assign ahead_eff = fill_r ? ram_rdata : ahead_r;
  assign ctrl_addr = {wd[5:0], first_r};

  vdpvlt_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    addr_nxt  = addr_r;
    pend_nxt  = pend_r;
    first_nxt = first_r;
    ahead_nxt = ahead_eff;
    fill_nxt  = 1'b0;
    flag_nxt  = flag_r;
    line_nxt  = line_r;
    irq_nxt   = irq_r;
    mode_nxt  = mode_r;
    ram_we    = clearing_r;
    ram_waddr = clr_addr_r;
    ram_wdata = 8'd0;
    ram_raddr = mem_index(addr_r);
    res_nxt   = '0;

    if (acc) begin
      case (func)
        FN_DATA_READ: begin
          res_nxt.rdata = ahead_eff;
          fill_nxt      = 1'b1;
          addr_nxt      = addr_r + 14'd1;
          pend_nxt      = 1'b0;
        end
        FN_DATA_WRITE: begin
          ram_we    = 1'b1;
          ram_waddr = mem_index(addr_r);
          ram_wdata = wd;
          ahead_nxt = wd;
          addr_nxt  = addr_r + 14'd1;
          pend_nxt  = 1'b0;
        end
        FN_STATUS: begin
          res_nxt.rdata = {flag_r, 7'd0};
          flag_nxt      = 1'b0;
          pend_nxt      = 1'b0;
        end
        FN_CONTROL: begin
          if (!pend_r) begin
            first_nxt = wd;
            pend_nxt  = 1'b1;
          end else begin
            pend_nxt = 1'b0;
            if (wd[7]) begin
              mode_nxt[wd[2:0]] = first_r;
            end else if (wd[6]) begin
              addr_nxt = ctrl_addr;
            end else begin
              ram_raddr = mem_index(ctrl_addr);
              fill_nxt  = 1'b1;
              addr_nxt  = ctrl_addr + 14'd1;
            end
          end
        end
        FN_LINE_END: begin
          irq_nxt             = 1'b0;
          res_nxt.line_number = line_r;
          if (line_r < VIS_LINE) begin
            res_nxt.draw_line = 1'b1;
          end else if (line_r == VIS_LINE) begin
            flag_nxt            = 1'b1;
            res_nxt.frame_start = 1'b1;
            irq_nxt             = mode_r[REG_MODE1][5];
          end
          line_nxt = line_r + 9'd1;
          if (line_nxt >= LPF_LINE) begin
            line_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end

    res_nxt.irq_pulse   = irq_nxt;
    res_nxt.screen_mode = screen_mode(mode_nxt[REG_MODE0], mode_nxt[REG_MODE1]);
    res_nxt.display_on  = mode_nxt[REG_MODE1][6];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      addr_r      <= '0;
      pend_r      <= 1'b0;
      first_r     <= '0;
      ahead_r     <= '0;
      fill_r      <= 1'b0;
      flag_r      <= 1'b0;
      line_r      <= '0;
      irq_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        mode_r[i] <= '0;
      end
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + MEM_AW'(1);
        if (clr_addr_r == MEM_LAST) begin
          clearing_r <= 1'b0;
        end
      end
      addr_r  <= addr_nxt;
      pend_r  <= pend_nxt;
      first_r <= first_nxt;
      ahead_r <= ahead_nxt;
      fill_r  <= fill_nxt;
      flag_r  <= flag_nxt;
      line_r  <= line_nxt;
      irq_r   <= irq_nxt;
      mode_r  <= mode_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r};

endmodule

`default_nettype wire

// ===== rtl/vdpvlt_checker.sv =====
// ----------------------------------------------------------------------------
// vdpvlt_checker: port-level checks for the VDP port and line timing block
// Watches the result stream for handshake stability and timing consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module vdpvlt_checker
  import vdpvlt_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  res_t res;
  assign res = out_tdata[22:0];

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // The start of vertical blank is reported on the line after the last visible one.
  a_frame_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.frame_start |-> res.line_number == VIS_LINE && !res.draw_line)
    else $error("frame start on wrong line");

  a_draw_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.draw_line |-> res.line_number < VIS_LINE)
    else $error("draw line outside visible area");

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res.line_number < LPF_LINE && !out_tdata[23])
    else $error("line number beyond frame or pad bit set");

  // While the memory is being cleared no word is taken, so no result appears.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("activity right after reset");

endmodule

bind vdp_vram_port_and_line_timing vdpvlt_checker u_vdpvlt_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stream-level test of the VDP CPU port and line timing block
// Drives bus accesses and scanline ticks through the input stream, predicts
// every result word from a private copy of the video memory, registers,
// address, latch and line counter, and checks each output word field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import vdpvlt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_WORDS = 1700;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int TAIL_CYCLES  = 20;
  localparam int IDLE_PCT     = 37;
  localparam int CALM_FIRST   = 700;
  localparam int CALM_LAST    = 1000;

  localparam func_t FN_SPARE_FIRST = 3'd5;
  localparam func_t FN_SPARE_MID   = 3'd6;
  localparam func_t FN_SPARE_LAST  = 3'd7;

  // Second control byte: bit 7 selects a register write, bit 6 skips prefetch.
  localparam logic [7:0] CB_REG_WRITE   = 8'h80;
  localparam logic [7:0] CB_NO_PREFETCH = 8'h40;

  localparam int R0_GFX2    = 1;
  localparam int R1_MULTI   = 3;
  localparam int R1_TEXT    = 4;
  localparam int R1_IRQ_EN  = 5;
  localparam int R1_DISPLAY = 6;

  typedef struct {
    func_t      fn;
    logic [7:0] wd;
    bit         hold;   // wait for every outstanding result before sending
  } bus_access_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] wdata
  logic [2:0]  in_tuser = '0;    // [2:0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [7:0] rdata, [8] irq_pulse, [9] frame_start, [10] draw_line,
  // [19:11] line_number, [21:20] screen_mode, [22] display_on, [23] zero
  logic [23:0] out_tdata;

  vdp_vram_port_and_line_timing uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Shadow state of the block.
  logic [7:0]        vram [MEM_BYTES];
  logic [7:0]        mregs [8];
  logic [ADDR_W-1:0] vaddr;
  logic              latch_full;
  logic [7:0]        latch_byte;
  logic [7:0]        ahead;
  logic              fflag;
  logic [LINE_W-1:0] scan_line;
  logic              irq;

  bus_access_t access_q [$];
  res_t        due_results [$];
  int          errors = 0;
  int          n_sent = 0;
  int          n_seen = 0;
  int          cycles = 0;
  int          n_work = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int vram_slot(logic [ADDR_W-1:0] a);
    return int'(a) % MEM_BYTES;
  endfunction

  task automatic apply_access(input func_t fn, input logic [7:0] wd);
    res_t r;
    logic [LINE_W-1:0] nxt;
    r = '0;
    case (fn)
      FN_DATA_READ: begin
        r.rdata = ahead;
        ahead = vram[vram_slot(vaddr)];
        vaddr = vaddr + ADDR_W'(1);
        latch_full = 1'b0;
      end
      FN_DATA_WRITE: begin
        vram[vram_slot(vaddr)] = wd;
        ahead = wd;
        vaddr = vaddr + ADDR_W'(1);
        latch_full = 1'b0;
      end
      FN_STATUS: begin
        r.rdata = {fflag, 7'd0};
        fflag = 1'b0;
        latch_full = 1'b0;
      end
      FN_CONTROL: begin
        if (!latch_full) begin
          latch_byte = wd;
          latch_full = 1'b1;
        end else begin
          latch_full = 1'b0;
          if ((wd & CB_REG_WRITE) != 0) begin
            mregs[wd[2:0]] = latch_byte;
          end else begin
            vaddr = {wd[5:0], latch_byte};
            if ((wd & CB_NO_PREFETCH) == 0) begin
              ahead = vram[vram_slot(vaddr)];
              vaddr = vaddr + ADDR_W'(1);
            end
          end
        end
      end
      FN_LINE_END: begin
        irq = 1'b0;
        r.line_number = scan_line;
        if (scan_line < VISIBLE_LINES) begin
          r.draw_line = 1'b1;
        end else if (scan_line == VISIBLE_LINES) begin
          // Start of vertical blank.
          fflag = 1'b1;
          r.frame_start = 1'b1;
          if (mregs[REG_MODE1][R1_IRQ_EN]) irq = 1'b1;
        end
        nxt = scan_line + LINE_W'(1);
        if (nxt >= LINES_PER_FRAME) nxt = '0;
        scan_line = nxt;
      end
      default: ;
    endcase
    r.irq_pulse = irq;
    if (mregs[REG_MODE1][R1_TEXT]) begin
      r.screen_mode = MODE_TEXT;
    end else if (mregs[REG_MODE1][R1_MULTI]) begin
      r.screen_mode = MODE_MULTI;
    end else if (mregs[REG_MODE0][R0_GFX2]) begin
      r.screen_mode = MODE_GFX2;
    end else begin
      r.screen_mode = MODE_GFX1;
    end
    r.display_on = mregs[REG_MODE1][R1_DISPLAY];
    due_results.push_back(r);
  endtask

  task automatic report(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report($sformatf("word %0d %s got %0h want %0h", n_seen, name, got, want));
    end
  endtask

  // Driver: presents the next queued access, holding it until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_access(func_t'(in_tuser), in_tdata);
        n_sent <= n_sent + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (access_q.size() != 0 && !(access_q[0].hold && due_results.size() != 0) &&
            ((n_sent >= CALM_FIRST && n_sent < CALM_LAST) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          in_tvalid <= 1'b1;
          in_tuser  <= access_q[0].fn;
          in_tdata  <= access_q[0].wd;
          void'(access_q.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes result words and compares them with the oldest prediction.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[22:0]);
        if (due_results.size() == 0) begin
          report($sformatf("unexpected word %0h", out_tdata));
        end else begin
          want = due_results.pop_front();
          check_field("rdata", 16'(got.rdata), 16'(want.rdata));
          check_field("irq_pulse", 16'(got.irq_pulse), 16'(want.irq_pulse));
          check_field("frame_start", 16'(got.frame_start), 16'(want.frame_start));
          check_field("draw_line", 16'(got.draw_line), 16'(want.draw_line));
          check_field("line_number", 16'(got.line_number), 16'(want.line_number));
          check_field("screen_mode", 16'(got.screen_mode), 16'(want.screen_mode));
          check_field("display_on", 16'(got.display_on), 16'(want.display_on));
          check_field("pad bit", 16'(out_tdata[23]), 16'd0);
        end
        n_seen <= n_seen + 1;
      end
      out_tready <= (n_seen >= CALM_FIRST && n_seen < CALM_LAST) ||
                    $urandom_range(99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** vdp_vram_port_and_line_timing: FAILED **");
      $finish;
    end
  end

  task automatic put(input func_t fn, input logic [7:0] wd, input bit hold = 1'b0);
    bus_access_t a;
    a.fn = fn;
    a.wd = wd;
    a.hold = hold;
    access_q.push_back(a);
    if (fn <= FN_LINE_END) n_work++;
  endtask

  task automatic put_control(input logic [7:0] first, input logic [7:0] second);
    put(FN_CONTROL, first);
    put(FN_CONTROL, second);
  endtask

  function automatic logic [7:0] pick_high();
    // Mostly the first 512 bytes so that reads find earlier writes.
    if ($urandom_range(9) == 0) return 8'($urandom_range(63));
    return 8'($urandom_range(1));
  endfunction

  initial begin
    int kind;
    int len;
    logic [7:0] v;
    foreach (vram[i]) vram[i] = '0;
    foreach (mregs[i]) mregs[i] = '0;
    vaddr = '0;
    latch_full = 1'b0;
    latch_byte = '0;
    ahead = '0;
    fflag = 1'b0;
    scan_line = '0;
    irq = 1'b0;

    // Directed part: reset values, address wrap, prefetch, latch reset,
    // mode priority, spare codes.
    put(FN_STATUS, 8'h00);
    put(FN_DATA_READ, 8'hFF);
    put_control(8'hFF, CB_NO_PREFETCH | 8'h3F);
    put(FN_DATA_WRITE, 8'hFF);
    put(FN_DATA_WRITE, 8'h00);
    put_control(8'hFF, 8'h3F);
    put(FN_DATA_READ, 8'h00);
    put(FN_DATA_READ, 8'h00);
    put_control(8'hFF, CB_REG_WRITE | 8'h79);
    put_control(8'h02, CB_REG_WRITE | 8'(REG_MODE0));
    put_control(8'h08, CB_REG_WRITE | 8'(REG_MODE1));
    put_control(8'h00, CB_REG_WRITE | 8'(REG_MODE1));
    // A status read between the two control bytes drops the first one.
    put(FN_CONTROL, 8'h12);
    put(FN_STATUS, 8'h00);
    put_control(8'h05, CB_NO_PREFETCH);
    put(FN_DATA_WRITE, 8'hA5);
    put(FN_SPARE_FIRST, 8'hFF);
    put(FN_SPARE_MID, 8'h00);
    put(FN_SPARE_LAST, 8'h5A);
    put(FN_LINE_END, 8'h00);
    put_control(8'h60, CB_REG_WRITE | 8'(REG_MODE1));

    // Random part: well-formed access sequences with random content,
    // long tick runs to get through whole frames, and some noise.
    while (n_work < TARGET_WORDS) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        len = $urandom_range(60, 1);
        repeat (len) put(FN_LINE_END, 8'($urandom()));
        if ($urandom_range(1)) put(FN_STATUS, 8'($urandom()));
      end else if (kind < 55) begin
        put_control(8'($urandom()), CB_NO_PREFETCH | pick_high());
        len = $urandom_range(8, 1);
        repeat (len) put(FN_DATA_WRITE, 8'($urandom()));
      end else if (kind < 72) begin
        v = ($urandom_range(3) == 0) ? CB_NO_PREFETCH : 8'h00;
        put_control(8'($urandom()), v | pick_high());
        len = $urandom_range(8, 1);
        repeat (len) put(FN_DATA_READ, 8'($urandom()));
      end else if (kind < 82) begin
        v = ($urandom_range(3) == 0) ? 8'($urandom_range(7)) : 8'($urandom_range(1));
        put_control(8'($urandom()), CB_REG_WRITE | (8'($urandom_range(15)) << 3) | v);
      end else if (kind < 88) begin
        len = $urandom_range(3, 1);
        repeat (len) put(FN_STATUS, 8'($urandom()));
      end else if (kind < 94) begin
        // Broken pair: a single control byte cut off by another access.
        put(FN_CONTROL, 8'($urandom()));
        put(func_t'($urandom_range(FN_STATUS)), 8'($urandom()));
      end else begin
        len = $urandom_range(4, 1);
        repeat (len) put(func_t'($urandom_range(FN_SPARE_LAST)), 8'($urandom()),
                         $urandom_range(19) == 0);
      end
      // Drain the pipe before the last access of a sequence now and then.
      if (n_work > 800 && n_work < 830) access_q[$].hold = 1'b1;
    end
    access_q[21].hold = 1'b1;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (access_q.size() != 0 || in_tvalid || due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** vdp_vram_port_and_line_timing: PASSED **");
    end else begin
      $display("** vdp_vram_port_and_line_timing: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
